[hw/rtl/swec_pkg.sv]
// shared types, sizes and helpers for the sliding window extreme cascade
package swec_pkg;

  localparam int WINDOW_MAX = 64;
  localparam int DATA_WIDTH = 32;
  localparam int WS_W       = 7;
  localparam int IDX_W      = $clog2(WINDOW_MAX);
  localparam int CNT_W      = $clog2(WINDOW_MAX + 1);
  localparam int GROUP_SIZE = 8;
  localparam int NUM_GROUPS = WINDOW_MAX / GROUP_SIZE;
  localparam int SUB_W      = $clog2(GROUP_SIZE);
  localparam int GRP_W      = IDX_W - SUB_W;
  localparam int PADDR_W    = 3;
  localparam int PDATA_W    = 32;

  typedef logic signed [DATA_WIDTH-1:0] sample_t;

  // configuration register indexes
  typedef enum logic [0:0] {
    REG_WINDOW_SIZE = 1'b0,
    REG_SELECT_MAX  = 1'b1
  } reg_idx_t;

  // slot pick request from the control to the pick stage
  typedef struct packed {
    logic             load;
    logic [IDX_W-1:0] idx;
  } pick_ctrl_t;

  function automatic logic more_extreme(input sample_t cand, input sample_t held,
                                        input logic sel_max);
    logic res;
    res = sel_max ? (cand > held) : (cand < held);
    return res;
  endfunction

endpackage

[hw/rtl/swec_cell.sv]
// one slot of the suffix extreme row
module swec_cell (
  input  logic              clk,
  input  logic              en,
  input  logic              sel_max,
  input  swec_pkg::sample_t sample,
  input  swec_pkg::sample_t prev,
  output swec_pkg::sample_t value_r
);

  swec_pkg::sample_t value_nxt;

  // take the neighbour's value, lowered (or raised) by the new sample
  always_comb begin
    value_nxt = swec_pkg::more_extreme(sample, prev, sel_max) ? sample : prev;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      value_r <= value_nxt;
    end
  end

endmodule

[hw/rtl/swec_pick.sv]
// two-level registered pick of one slot out of the cell row
module swec_pick (
  input  logic                 clk,
  input  swec_pkg::pick_ctrl_t ctrl,
  input  swec_pkg::sample_t    cells [swec_pkg::WINDOW_MAX],
  output swec_pkg::sample_t    held_value
);

  swec_pkg::sample_t                 grp_vals_r   [swec_pkg::NUM_GROUPS];
  swec_pkg::sample_t                 grp_vals_nxt [swec_pkg::NUM_GROUPS];
  logic [swec_pkg::GRP_W-1:0]        grp_r;

  // first level: one entry per group, same offset in every group
  always_comb begin
    logic [swec_pkg::IDX_W-1:0] cell_idx;
    cell_idx = '0;
    for (int g = 0; g < swec_pkg::NUM_GROUPS; g++) begin
      cell_idx = {swec_pkg::GRP_W'(g), ctrl.idx[swec_pkg::SUB_W-1:0]};
      grp_vals_nxt[g] = cells[cell_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      grp_vals_r <= grp_vals_nxt;
      grp_r      <= ctrl.idx[swec_pkg::IDX_W-1:swec_pkg::SUB_W];
    end
  end

  // second level: choose the group
  assign held_value = grp_vals_r[grp_r];

endmodule

[hw/rtl/sliding_window_extreme_cascade.sv]
// top level of the sliding window extreme cascade
//
//  channel  direction  handshake               payload
//  in       sink       in_valid / in_stall     in_sample, in_end_of_stream
//  out      source     out_valid / out_stall   out_window_extreme, out_final_result
//  cfg      apb slave  psel, penable, pready   paddr, pwdata, prdata
//
// one item is taken per clock while in_stall is low; the cell row updates in the cycle of acceptance
// a result leaves through the pick stage register and then the output register: the slot pick is two mux levels,
//   each closed by a register (group pick, then group select and compare)
// rst_n is synchronous: clears the slot count, the pipeline valids and the
//   registers (window_size 1, select_max 0); slot contents are left as they are
// a stalled result holds the pick stage, which then stalls the input
module sliding_window_extreme_cascade (
  input  logic                           clk,
  input  logic                           rst_n,
  // input items
  input  logic                           in_valid,
  output logic                           in_stall,
  input  swec_pkg::sample_t              in_sample,
  input  logic                           in_end_of_stream,
  // result items
  output logic                           out_valid,
  input  logic                           out_stall,
  output swec_pkg::sample_t              out_window_extreme,
  output logic                           out_final_result,
  // configuration
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [swec_pkg::PADDR_W-1:0]   paddr,
  input  logic [swec_pkg::PDATA_W-1:0]   pwdata,
  output logic [swec_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready
);

  // configuration registers
  logic [swec_pkg::WS_W-1:0]  window_size_r;
  logic                       select_max_r;
  logic                       cfg_wr;
  swec_pkg::reg_idx_t         cfg_idx;

  // slot count and window
  logic [swec_pkg::CNT_W-1:0] held_r, held_nxt;
  logic [swec_pkg::CNT_W-1:0] held_new;
  logic [swec_pkg::CNT_W-1:0] win_eff;
  logic                       accept;
  logic                       full;
  logic                       emit;
  logic                       k_zero;
  logic [swec_pkg::IDX_W-1:0] pick_idx;

  // pick stage
  logic                       s1_valid_r, s1_valid_nxt;
  logic                       s1_emit_r;
  logic                       s1_last_r;
  logic                       s1_k_zero_r;
  swec_pkg::sample_t          s1_sample_r;
  logic                       s1_move;
  swec_pkg::sample_t          held_value;
  swec_pkg::sample_t          result;

  // output register
  logic                       out_valid_r, out_valid_nxt;
  swec_pkg::sample_t          out_extreme_r;
  logic                       out_final_r;

  swec_pkg::pick_ctrl_t       pick_ctrl;
  swec_pkg::sample_t          cells [swec_pkg::WINDOW_MAX];

  // ---------------------------------------------------------------- config
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = swec_pkg::reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_size_r <= swec_pkg::WS_W'(1);
      select_max_r  <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        swec_pkg::REG_WINDOW_SIZE: window_size_r <= pwdata[swec_pkg::WS_W-1:0];
        swec_pkg::REG_SELECT_MAX:  select_max_r  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      swec_pkg::REG_WINDOW_SIZE: prdata = swec_pkg::PDATA_W'(window_size_r);
      swec_pkg::REG_SELECT_MAX:  prdata = swec_pkg::PDATA_W'(select_max_r);
      default:                   prdata = '0;
    endcase
  end

  // zero counts as one, anything above the row length saturates
  always_comb begin
    if (window_size_r == '0) begin
      win_eff = swec_pkg::CNT_W'(1);
    end else if (swec_pkg::CNT_W'(window_size_r) > swec_pkg::CNT_W'(swec_pkg::WINDOW_MAX)) begin
      win_eff = swec_pkg::CNT_W'(swec_pkg::WINDOW_MAX);
    end else begin
      win_eff = swec_pkg::CNT_W'(window_size_r);
    end
  end

  // ---------------------------------------------------------------- cell row
  // cell 0 holds the newest sample, cell j the extreme of the newest j+1;
  // each accepted item shifts the row by one, lowering (or raising) every value on the way
  assign accept = in_valid && !in_stall;

  for (genvar j = 0; j < swec_pkg::WINDOW_MAX; j++) begin : g_cell
    if (j == 0) begin : g_head
      swec_cell u_cell (
        .clk     (clk),
        .en      (accept),
        .sel_max (select_max_r),
        .sample  (in_sample),
        .prev    (in_sample),
        .value_r (cells[j])
      );
    end else begin : g_body
      swec_cell u_cell (
        .clk     (clk),
        .en      (accept),
        .sel_max (select_max_r),
        .sample  (in_sample),
        .prev    (cells[j-1]),
        .value_r (cells[j])
      );
    end
  end

  // ---------------------------------------------------------------- control
  // the emitted slot, counted from the newest, is window-1 when the window is
  // full, else (end of stream) the oldest held slot; its updated value comes
  // from the old cell one place nearer the head, lowered (or raised) by the new sample
  assign held_new = held_r + swec_pkg::CNT_W'(1);
  assign full     = (held_new >= win_eff);
  assign emit     = full || in_end_of_stream;

  always_comb begin
    if (full) begin
      k_zero   = (win_eff == swec_pkg::CNT_W'(1));
      pick_idx = swec_pkg::IDX_W'(win_eff - swec_pkg::CNT_W'(2));
    end else begin
      k_zero   = (held_r == '0);
      pick_idx = swec_pkg::IDX_W'(held_r - swec_pkg::CNT_W'(1));
    end
  end

  always_comb begin
    held_nxt = held_r;
    if (accept) begin
      if (in_end_of_stream) begin
        held_nxt = '0;
      end else if (full) begin
        held_nxt = win_eff - swec_pkg::CNT_W'(1);
      end else begin
        held_nxt = held_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
    end else begin
      held_r <= held_nxt;
    end
  end

  // ---------------------------------------------------------------- pick stage
  assign pick_ctrl = '{load: accept, idx: pick_idx};

  swec_pick u_pick (
    .clk        (clk),
    .ctrl       (pick_ctrl),
    .cells      (cells),
    .held_value (held_value)
  );

  // an item without result leaves the stage whenever it likes
  assign s1_move  = s1_valid_r && (!s1_emit_r || !out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_move;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_move) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_emit_r   <= emit;
      s1_last_r   <= in_end_of_stream;
      s1_k_zero_r <= k_zero;
      s1_sample_r <= in_sample;
    end
  end

  // final compare; the newest slot is the sample itself
  always_comb begin
    if (s1_k_zero_r) begin
      result = s1_sample_r;
    end else if (swec_pkg::more_extreme(s1_sample_r, held_value, select_max_r)) begin
      result = s1_sample_r;
    end else begin
      result = held_value;
    end
  end

  // ---------------------------------------------------------------- output
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_move && s1_emit_r) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move && s1_emit_r) begin
      out_extreme_r <= result;
      out_final_r   <= s1_last_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_window_extreme = out_extreme_r;
  assign out_final_result   = out_final_r;

`ifndef SYNTHESIS
  // the row never has to hold more than one slot short of its length
  a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
    held_r < swec_pkg::CNT_W'(swec_pkg::WINDOW_MAX))
    else $error("slot count beyond row length");

  // the last item of a stream empties the row
  a_eos_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_end_of_stream |=> held_r == '0)
    else $error("slot count not cleared after end of stream");

  // the last item of a stream always produces a final result
  a_eos_emits: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_end_of_stream |=> s1_valid_r && s1_emit_r && s1_last_r)
    else $error("end of stream item without result");

  // a pending result is never dropped while the output is blocked
  a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s1_emit_r && out_valid_r && out_stall |=> s1_valid_r)
    else $error("pick stage lost a result under stall");
`endif

endmodule

[tb/window_extreme_checker.sv]
`timescale 1ns / 100ps
// checker for the sliding window extreme cascade: tracks the slot row and compares results
module window_extreme_checker
  import swec_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  sample_t            in_sample,
  input  logic               in_end_of_stream,
  input  logic               out_valid,
  input  logic               out_stall,
  input  sample_t            out_window_extreme,
  input  logic               out_final_result,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  input  logic               pready,
  output int                 fail_count,
  output int                 pending_count
);

  typedef struct packed {
    sample_t extreme;
    logic    final_flag;
  } window_result_t;

  sample_t         slot_extremes [WINDOW_MAX];
  int              slots_held;
  logic [WS_W-1:0] window_reg;
  logic            track_max;
  window_result_t  expected_results [$];

  // zero acts as one, anything past the row length saturates
  function automatic int span_of(input logic [WS_W-1:0] w);
    int span;
    span = (w == 0) ? 1 : int'(w);
    if (span > WINDOW_MAX) span = WINDOW_MAX;
    return span;
  endfunction

  task automatic absorb_sample(input sample_t s, input logic last);
    int             span;
    int             first;
    window_result_t res;
    span = span_of(window_reg);
    for (int i = 0; i < slots_held; i++) begin
      if (track_max ? (s > slot_extremes[i]) : (s < slot_extremes[i]))
        slot_extremes[i] = s;
    end
    if (slots_held < WINDOW_MAX) begin
      slot_extremes[slots_held] = s;
      slots_held++;
    end
    if (slots_held >= span) begin
      first          = slots_held - span;
      res.extreme    = slot_extremes[first];
      res.final_flag = last;
      expected_results.insert(expected_results.size(), res);
      if (last) begin
        slots_held = 0;
      end else begin
        for (int j = 0; j < span - 1; j++)
          slot_extremes[j] = slot_extremes[first + 1 + j];
        slots_held = span - 1;
      end
    end else if (last) begin
      res.extreme    = slot_extremes[0];
      res.final_flag = 1'b1;
      expected_results.insert(expected_results.size(), res);
      slots_held = 0;
    end
  endtask

  always @(posedge clk) begin : watch
    window_result_t want;
    if (!rst_n) begin
      slots_held = 0;
      window_reg = 1;
      track_max  = 1'b0;
      fail_count = 0;
      expected_results.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (reg_idx_t'(paddr[2]) == REG_WINDOW_SIZE) window_reg = pwdata[WS_W-1:0];
        else track_max = pwdata[0];
      end
      if (in_valid && !in_stall) absorb_sample(in_sample, in_end_of_stream);
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result: expected none, got extreme %0d final %0b",
                   $time, out_window_extreme, out_final_result);
        end else begin
          want = expected_results[0];
          expected_results.delete(0);
          if (out_window_extreme !== want.extreme) begin
            fail_count++;
            $display("%0t: window_extreme mismatch: expected %0d, got %0d",
                     $time, want.extreme, out_window_extreme);
          end
          if (out_final_result !== want.final_flag) begin
            fail_count++;
            $display("%0t: final_result mismatch: expected %0b, got %0b",
                     $time, want.final_flag, out_final_result);
          end
        end
      end
    end
    pending_count = expected_results.size();
  end

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps
// testbench top: clock, reset, item and register stimulus, and the verdict
module testbench;
  import swec_pkg::*;

  localparam int N_PHASES        = 8;
  localparam int ITEMS_PER_PHASE = 175;
  localparam int LONG_HOLD       = 300;      // receiver hold-off in the pressure phase
  localparam int DRAIN_CYCLES    = 8;        // well past the pick and output registers
  localparam int CYCLE_LIMIT     = 400000;

  localparam sample_t SAMPLE_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
  localparam sample_t SAMPLE_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};

  // per-phase settings: window size, mode, and idling pattern by phase modulo four
  localparam int PHASE_WINDOW [N_PHASES] = '{1, 2, 3, 8, 64, 5, 64, 17};
  localparam int PHASE_MAX    [N_PHASES] = '{0, 1, 0, 1, 0, 1, 1, 0};
  localparam int SEND_IDLE    [4]        = '{0, 48, 0, 30};
  localparam int RECV_STALL   [4]        = '{0, 0, 48, 30};

  logic               clk;
  logic               rst_n            = 1'b0;
  logic               in_valid         = 1'b0;
  logic               in_stall;
  sample_t            in_sample        = '0;
  logic               in_end_of_stream = 1'b0;
  logic               out_valid;
  logic               out_stall        = 1'b0;
  sample_t            out_window_extreme;
  logic               out_final_result;
  logic               psel             = 1'b0;
  logic               penable          = 1'b0;
  logic               pwrite           = 1'b0;
  logic [PADDR_W-1:0] paddr            = '0;
  logic [PDATA_W-1:0] pwdata           = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  int fail_count;
  int pending_count;
  int cycle_count;

  // idling knobs for the sender and the receiver
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_requests  = 0;

  sliding_window_extreme_cascade DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_sample          (in_sample),
    .in_end_of_stream   (in_end_of_stream),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_window_extreme (out_window_extreme),
    .out_final_result   (out_final_result),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  window_extreme_checker u_check (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_sample          (in_sample),
    .in_end_of_stream   (in_end_of_stream),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_window_extreme (out_window_extreme),
    .out_final_result   (out_final_result),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .pready             (pready),
    .fail_count         (fail_count),
    .pending_count      (pending_count)
  );

  // 2 ns clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // watchdog: a correct run finishes far inside this
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TEST FAILED");
    $finish;
  end

  // receiver: random stalls, or a long counted hold-off when one is asked for
  initial begin : receiver
    int hold_served;
    int hold_left;
    hold_served = 0;
    hold_left   = 0;
    forever begin
      @(posedge clk);
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left   = LONG_HOLD;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // mostly full-range values, with extremes and a narrow band so equal samples turn up
  function automatic sample_t random_sample();
    case ($urandom_range(9))
      0:       return SAMPLE_MIN;
      1:       return SAMPLE_MAX;
      2, 3, 4: return sample_t'(int'($urandom_range(16)) - 8);
      default: return sample_t'($urandom);
    endcase
  endfunction

  // offer one item after an optional random gap, return once it is taken
  task automatic send_item(input sample_t s, input logic eos);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_sample        <= s;
    in_end_of_stream <= eos;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // apb write: setup cycle, access cycle, then the bus is released
  task automatic write_reg(input reg_idx_t idx, input int unsigned value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= PDATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // stop offering, let every expected result out, then allow for an item
  // still in flight that produces nothing
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // random streams: mostly well-formed ones that fill the window, some that end
  // early, a few very short ones and the odd stray end flag; the last stream
  // of a phase is cut and carries on under the next phase's settings
  task automatic run_phase(input int budget, input int span);
    int   sent;
    int   len;
    int   pick;
    logic eos;
    sent = 0;
    while (sent < budget) begin
      pick = $urandom_range(99);
      if (pick < 8)       len = $urandom_range(3, 1);
      else if (pick < 25) len = $urandom_range(span, 1);
      else                len = $urandom_range(2 * span + 8, span);
      for (int k = 0; k < len && sent < budget; k++) begin
        eos = (k == len - 1) || ($urandom_range(99) == 0);
        send_item(random_sample(), eos);
        sent++;
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed: field extremes with a window of one
    write_reg(REG_WINDOW_SIZE, 1);
    write_reg(REG_SELECT_MAX, 0);
    send_item(SAMPLE_MIN, 1'b0);
    send_item(SAMPLE_MAX, 1'b0);
    send_item(sample_t'(0), 1'b0);
    send_item(sample_t'(-1), 1'b1);
    settle();

    // maximum mode, equal samples and the top value inside a window of three
    write_reg(REG_WINDOW_SIZE, 3);
    write_reg(REG_SELECT_MAX, 1);
    send_item(sample_t'(5), 1'b0);
    send_item(sample_t'(5), 1'b0);
    send_item(sample_t'(-7), 1'b0);
    send_item(sample_t'(5), 1'b0);
    send_item(SAMPLE_MAX, 1'b0);
    send_item(sample_t'(-2), 1'b1);
    settle();

    // stream ends before the window has filled
    write_reg(REG_WINDOW_SIZE, 4);
    write_reg(REG_SELECT_MAX, 0);
    send_item(sample_t'(10), 1'b0);
    send_item(sample_t'(-3), 1'b1);
    settle();

    // window lowered mid-stream: older slots go together
    write_reg(REG_WINDOW_SIZE, 5);
    send_item(sample_t'(9), 1'b0);
    send_item(sample_t'(1), 1'b0);
    send_item(sample_t'(7), 1'b0);
    send_item(sample_t'(3), 1'b0);
    settle();
    write_reg(REG_WINDOW_SIZE, 2);
    send_item(sample_t'(8), 1'b0);
    send_item(sample_t'(6), 1'b1);
    settle();

    // mode flipped mid-stream: held slots keep their values
    write_reg(REG_WINDOW_SIZE, 3);
    send_item(sample_t'(4), 1'b0);
    send_item(sample_t'(2), 1'b0);
    settle();
    write_reg(REG_SELECT_MAX, 1);
    send_item(sample_t'(1), 1'b0);
    send_item(sample_t'(9), 1'b1);
    settle();

    // random phases across settings and idling patterns
    for (int p = 0; p < N_PHASES; p++) begin
      send_idle_pct  = SEND_IDLE[p % 4];
      recv_stall_pct = RECV_STALL[p % 4];
      write_reg(REG_WINDOW_SIZE, PHASE_WINDOW[p]);
      write_reg(REG_SELECT_MAX, PHASE_MAX[p]);
      // long receiver hold-off while the sender keeps offering, so the block backs up
      if (p == 1) hold_requests++;
      run_phase(ITEMS_PER_PHASE, PHASE_WINDOW[p]);
      settle();
    end

    if (fail_count == 0 && pending_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/swec_pkg.sv
hw/rtl/swec_cell.sv
hw/rtl/swec_pick.sv
hw/rtl/sliding_window_extreme_cascade.sv
tb/window_extreme_checker.sv
tb/testbench.sv
